// ===== hdl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types and constants of the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;
    localparam int unsigned INV_EXP_OFFSET = 2;

    // operation codes on the input tuser
    localparam logic OP_POWER   = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    // operand selection of the modular multiplier
    typedef enum logic [2:0] {
        MOP_REDUCE = 3'b001,
        MOP_MUL    = 3'b010,
        MOP_SQR    = 3'b100
    } t_mop;

    typedef struct packed {
        logic load;
        logic mul_start;
        t_mop mul_op;
        logic e_shift;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic e_zero;
        logic e_lsb;
        logic m_small;
    } t_sts;

endpackage

// ===== hdl/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer for right-to-left square and multiply
// ----------------------------------------------------------------------------
module mexp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_free,
    output logic            o_emit,
    input  mexp_pkg::t_sts  i_sts,
    output mexp_pkg::t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RED   = 7'b0000010,
        S_RWAIT = 7'b0000100,
        S_STEP  = 7'b0001000,
        S_MWAIT = 7'b0010000,
        S_SWAIT = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.mul_start = 1'b0;
        o_cmd.mul_op    = mexp_pkg::MOP_REDUCE;
        o_cmd.e_shift   = 1'b0;
        o_in_ready      = 1'b0;
        o_emit          = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                if (i_sts.m_small) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = mexp_pkg::MOP_REDUCE;
                    n_state         = S_RWAIT;
                end
            end
            S_RWAIT: begin
                if (!i_sts.mul_busy) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (i_sts.e_zero) begin
                    n_state = S_FIN;
                end else if (i_sts.e_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = mexp_pkg::MOP_MUL;
                    n_state         = S_MWAIT;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = mexp_pkg::MOP_SQR;
                    o_cmd.e_shift   = 1'b1;
                    n_state         = S_SWAIT;
                end
            end
            S_MWAIT: begin
                if (!i_sts.mul_busy) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = mexp_pkg::MOP_SQR;
                    o_cmd.e_shift   = 1'b1;
                    n_state         = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (!i_sts.mul_busy) begin
                    n_state = S_STEP;
                end
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/mexp_dp.sv =====
// ----------------------------------------------------------------------------
// mexp_dp
// operand registers, exponent shifter and bit-serial modular multiplier
// ----------------------------------------------------------------------------
module mexp_dp #(
    parameter int unsigned MOD_WIDTH = 31,
    parameter int unsigned EXP_WIDTH = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mexp_pkg::t_cmd       i_cmd,
    output mexp_pkg::t_sts       o_sts,
    input  logic [MOD_WIDTH-1:0] i_modulus,
    input  logic                 i_operation,
    input  logic [MOD_WIDTH-1:0] i_base,
    input  logic [EXP_WIDTH-1:0] i_exponent,
    output logic [MOD_WIDTH-1:0] o_result
);

    localparam int unsigned EW = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
    localparam int unsigned SW = MOD_WIDTH + 2;
    localparam int unsigned CW = $clog2(MOD_WIDTH + 1);

    logic [MOD_WIDTH-1:0] r_m;
    logic [MOD_WIDTH-1:0] r_acc;
    logic [MOD_WIDTH-1:0] r_b;
    logic [EW-1:0]        r_e;
    logic [MOD_WIDTH-1:0] r_mp;
    logic [MOD_WIDTH-1:0] r_mx;
    logic [MOD_WIDTH-1:0] r_my;
    logic [CW-1:0]        r_cnt;
    logic                 r_mbusy;
    mexp_pkg::t_mop       r_mop;

    logic [SW-1:0]        w_sum;
    logic [SW-1:0]        w_m1;
    logic [SW-1:0]        w_m2;
    logic [SW-1:0]        w_red;
    logic [MOD_WIDTH-1:0] n_mp;

    // one multiplier bit per cycle, msb first
    assign w_m1  = SW'(r_m);
    assign w_m2  = SW'(r_m) << 1;
    assign w_sum = (SW'(r_mp) << 1) + (r_my[MOD_WIDTH-1] ? SW'(r_mx) : SW'(0));

    always_comb begin
        if (w_sum >= w_m2) begin
            w_red = w_sum - w_m2;
        end else if (w_sum >= w_m1) begin
            w_red = w_sum - w_m1;
        end else begin
            w_red = w_sum;
        end
        n_mp = w_red[MOD_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_cnt   <= '0;
            r_m     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_m <= i_modulus;
            end
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_cnt   <= CW'(MOD_WIDTH);
            end else if (r_mbusy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_mbusy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_b   <= i_base;
            r_acc <= MOD_WIDTH'(1);
            if (i_operation == mexp_pkg::OP_INVERSE) begin
                r_e <= EW'(i_modulus) - EW'(mexp_pkg::INV_EXP_OFFSET);
            end else begin
                r_e <= EW'(i_exponent);
            end
        end else begin
            if (i_cmd.e_shift) begin
                r_e <= r_e >> 1;
            end
            if (r_mbusy && r_cnt == CW'(1)) begin
                case (r_mop)
                    mexp_pkg::MOP_MUL: begin
                        r_acc <= n_mp;
                    end
                    default: begin
                        r_b <= n_mp;
                    end
                endcase
            end
        end
        if (i_cmd.mul_start) begin
            r_mp  <= '0;
            r_mop <= i_cmd.mul_op;
            case (i_cmd.mul_op)
                mexp_pkg::MOP_REDUCE: begin
                    r_mx <= MOD_WIDTH'(1);
                    r_my <= r_b;
                end
                mexp_pkg::MOP_MUL: begin
                    r_mx <= r_b;
                    r_my <= r_acc;
                end
                default: begin
                    r_mx <= r_b;
                    r_my <= r_b;
                end
            endcase
        end else if (r_mbusy) begin
            r_mp <= n_mp;
            r_my <= r_my << 1;
        end
    end

    assign o_sts.mul_busy = r_mbusy;
    assign o_sts.e_zero   = (r_e == '0);
    assign o_sts.e_lsb    = r_e[0];
    assign o_sts.m_small  = (r_m < MOD_WIDTH'(2));
    assign o_result       = o_sts.m_small ? '0 : r_acc;

    // partial product stays reduced during a multiplication
    a_mp_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mbusy && !o_sts.m_small) |=> (r_mp < r_m))
        else $error("partial product not reduced");

    // accumulator stays reduced once loaded
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_sts.m_small && !r_mbusy) |-> (r_acc < r_m))
        else $error("accumulator not reduced");

    // bit counter runs exactly while the multiplier is busy
    a_cnt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mbusy == (r_cnt != '0))
        else $error("multiplier counter out of step");

    // no new multiplication starts while one is running
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mbusy |-> !i_cmd.mul_start)
        else $error("multiplier restarted while busy");

endmodule

// ===== hdl/modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation
// base to the power of an exponent modulo a configured modulus
// ----------------------------------------------------------------------------
// input word: tdata holds base (low bits) then exponent, tuser the operation
// (0 power, 1 inverse by exponent modulus minus two). output word: result.
// the modulus, written through i_cfg_we / i_cfg_wdata, resets to 1000000007;
// the user must write it only while idle, the block does not enforce that.
// one word is processed at a time: s_axis_tready is high only in S_IDLE.
// sequence: a base reduction, then per exponent bit a check, a multiply for a
// one bit and a squaring, then a final check and the output register. the
// bit-serial modular multiplier works one multiplier bit per cycle. a modulus
// below two skips the reduction and the exponent bits and gives 0.
// a result sits in the output register until m_axis_tready; the next input
// word is accepted meanwhile, and a finished result waits in the sequencer
// while the output register is full.
// reset is synchronous, active low, and clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int unsigned MOD_WIDTH = 31,
    parameter int unsigned EXP_WIDTH = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [MOD_WIDTH-1:0] i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // base, exponent, zero fill
    input  logic [((MOD_WIDTH+EXP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  logic [0:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // result, zero fill
    output logic [((MOD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    localparam int unsigned OUT_W = ((MOD_WIDTH + 7) / 8) * 8;

    logic [MOD_WIDTH-1:0] r_modulus;
    logic                 r_out_valid;
    logic [MOD_WIDTH-1:0] r_out_result;

    mexp_pkg::t_cmd       w_cmd;
    mexp_pkg::t_sts       w_sts;
    logic                 w_emit;
    logic                 w_out_free;
    logic [MOD_WIDTH-1:0] w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_WIDTH'(mexp_pkg::MODULUS_RESET);
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_free (w_out_free),
        .o_emit     (w_emit),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mexp_dp #(
        .MOD_WIDTH (MOD_WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_modulus   (r_modulus),
        .i_operation (s_axis_tuser[0]),
        .i_base      (s_axis_tdata[MOD_WIDTH-1:0]),
        .i_exponent  (s_axis_tdata[MOD_WIDTH+EXP_WIDTH-1:MOD_WIDTH]),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_result);

endmodule
